// ===== src/cbce_pkg.sv =====
// ----------------------------------------------------------------------------
// cbce_pkg
// Shared types and constants for the CPU bus cycle extractor: cycle kinds,
// register indexes, reset values and the structs passed between modules.
// ----------------------------------------------------------------------------
package cbce_pkg;

    // Default ring length of the sample index and width of the span counters
    localparam int DEF_INDEX_RING = 8192;
    localparam int DEF_COUNT_BITS = 16;

    // Fixed field widths of the result word, the sample and the configuration port
    localparam int COUNT_OUT_W = 16;
    localparam int INDEX_OUT_W = 13;
    localparam int SAMPLE_W    = 16;
    localparam int DATA_W      = 8;
    localparam int POS_W       = 4;
    localparam int PHI_W       = 5;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 5;

    typedef enum logic [2:0] {
        KIND_NONE     = 3'd0,
        KIND_FETCH    = 3'd1,
        KIND_MEM_RD   = 3'd2,
        KIND_MEM_WR   = 3'd3,
        KIND_IO_RD    = 3'd4,
        KIND_IO_WR    = 3'd5,
        KIND_INT_ACK  = 3'd6,
        KIND_RESERVED = 3'd7
    } kind_t;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DATA_POS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_M1_POS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RD_POS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WR_POS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MREQ_POS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IORQ_POS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WAIT_POS = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PHI_POS  = 3'd7;

    // Register reset values
    localparam logic [POS_W-1:0] RST_DATA_POS = 4'd0;
    localparam logic [POS_W-1:0] RST_M1_POS   = 4'd8;
    localparam logic [POS_W-1:0] RST_RD_POS   = 4'd9;
    localparam logic [POS_W-1:0] RST_WR_POS   = 4'd10;
    localparam logic [POS_W-1:0] RST_MREQ_POS = 4'd11;
    localparam logic [POS_W-1:0] RST_IORQ_POS = 4'd12;
    localparam logic [POS_W-1:0] RST_WAIT_POS = 4'd13;
    localparam logic [PHI_W-1:0] RST_PHI_POS  = 5'd15;

    typedef struct packed {
        logic [POS_W-1:0] data_pos;
        logic [POS_W-1:0] m1_pos;
        logic [POS_W-1:0] rd_pos;
        logic [POS_W-1:0] wr_pos;
        logic [POS_W-1:0] mreq_pos;
        logic [POS_W-1:0] iorq_pos;
        logic [POS_W-1:0] wait_pos;
        logic [PHI_W-1:0] phi_pos;   // two's complement, negative: no clock
    } cfg_t;

    // Fields picked out of one sample
    typedef struct packed {
        kind_t             kind;
        logic [DATA_W-1:0] data;
        logic              phi;
        logic              wait_n;
        logic              no_clock;
    } dec_t;

    // One span summary
    typedef struct packed {
        kind_t                  cycle_kind;
        logic [DATA_W-1:0]      cycle_data;
        logic [COUNT_OUT_W-1:0] sample_count;
        logic [COUNT_OUT_W-1:0] clock_count;
        logic [COUNT_OUT_W-1:0] wait_count;
        logic [INDEX_OUT_W-1:0] start_index;
        logic                   direct_transition;
    } result_t;

endpackage

// ===== src/cpu_bus_cycle_extractor_top.sv =====
// ----------------------------------------------------------------------------
// cpu_bus_cycle_extractor_top
// Bus cycle monitor for an 8-bit CPU: classify logic-analyser samples and
// emit one summary word for each span that ends at a cycle start.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                    Payload
//  -------   --------------------------   ------------------------------------
//  in        in_valid / in_stall          sample
//  out       out_valid / out_stall        cycle_kind, cycle_data, sample_count,
//                                         clock_count, wait_count, start_index,
//                                         direct_transition
//  cfg       cfg_write_en                 cfg_index, cfg_data
//
//  Throughput is one sample word per clock while the output is not stalled.
//  A sample lands in the input register on acceptance; when the output
//  register is free it is decoded, folded into the span state and, on a
//  cycle start, its summary word is loaded into the output register.
//  Reset (rst_n low, asynchronous) restores the register defaults and clears
//  the span state. A stalled output word holds the input register, which in
//  turn stalls the input channel.
// ----------------------------------------------------------------------------
module cpu_bus_cycle_extractor_top
    import cbce_pkg::*;
#(
    parameter int INDEX_RING = DEF_INDEX_RING,
    parameter int COUNT_BITS = DEF_COUNT_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration write port
    input  logic                   cfg_write_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // sample channel
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [SAMPLE_W-1:0]    sample,
    // summary channel
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [2:0]             cycle_kind,
    output logic [DATA_W-1:0]      cycle_data,
    output logic [COUNT_OUT_W-1:0] sample_count,
    output logic [COUNT_OUT_W-1:0] clock_count,
    output logic [COUNT_OUT_W-1:0] wait_count,
    output logic [INDEX_OUT_W-1:0] start_index,
    output logic                   direct_transition
);

    cfg_t                cfg;
    dec_t                dec;
    result_t             result;
    logic                emit;

    logic                in_valid_reg;
    logic                in_valid_next;
    logic [SAMPLE_W-1:0] sample_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    result_t             result_reg;

    logic                out_free;
    logic                step;
    logic                in_take;

    // Output register is free when empty or being drained this cycle
    assign out_free = !out_valid_reg || !out_stall;
    // Fold the held sample into the span state when its word can move on
    assign step     = in_valid_reg && out_free;
    // Input register takes a new word when empty or advancing
    assign in_stall = in_valid_reg && !step;
    assign in_take  = in_valid && !in_stall;

    assign in_valid_next  = in_stall ? in_valid_reg : in_valid;
    assign out_valid_next = out_free ? (step && emit) : out_valid_reg;

    cbce_cfg_regs u_cfg
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    cbce_decode u_decode
    (
        .sample (sample_reg),
        .cfg    (cfg),
        .dec    (dec)
    );

    cbce_span #(
        .INDEX_RING (INDEX_RING),
        .COUNT_BITS (COUNT_BITS)
    ) u_span
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .dec    (dec),
        .emit   (emit),
        .result (result)
    );

    // Handshake state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            sample_reg <= sample;
        end
        if (step && emit && out_free)
        begin
            result_reg <= result;
        end
    end

    assign out_valid         = out_valid_reg;
    assign cycle_kind        = result_reg.cycle_kind;
    assign cycle_data        = result_reg.cycle_data;
    assign sample_count      = result_reg.sample_count;
    assign clock_count       = result_reg.clock_count;
    assign wait_count        = result_reg.wait_count;
    assign start_index       = result_reg.start_index;
    assign direct_transition = result_reg.direct_transition;

    // A new summary word only appears after a sample was folded in
    a_out_follows_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_valid_reg))
        else $error("summary word appeared without a held sample");

    // A blocked summary word keeps the held sample in place
    a_hold_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && out_stall) |=>
            (in_valid_reg && $stable(sample_reg)))
        else $error("held sample lost while output was blocked");

    // The input side only stalls with a sample in the input register
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_valid_reg && out_valid_reg))
        else $error("input stalled with nothing to hold it");

endmodule

// ===== src/cbce_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// cbce_cfg_regs
// Bit-position registers, written through the plain write port.
// ----------------------------------------------------------------------------
module cbce_cfg_regs
    import cbce_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_DATA_POS: cfg_next.data_pos = cfg_data[POS_W-1:0];
                REG_M1_POS:   cfg_next.m1_pos   = cfg_data[POS_W-1:0];
                REG_RD_POS:   cfg_next.rd_pos   = cfg_data[POS_W-1:0];
                REG_WR_POS:   cfg_next.wr_pos   = cfg_data[POS_W-1:0];
                REG_MREQ_POS: cfg_next.mreq_pos = cfg_data[POS_W-1:0];
                REG_IORQ_POS: cfg_next.iorq_pos = cfg_data[POS_W-1:0];
                REG_WAIT_POS: cfg_next.wait_pos = cfg_data[POS_W-1:0];
                REG_PHI_POS:  cfg_next.phi_pos  = cfg_data[PHI_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.data_pos <= RST_DATA_POS;
            cfg_reg.m1_pos   <= RST_M1_POS;
            cfg_reg.rd_pos   <= RST_RD_POS;
            cfg_reg.wr_pos   <= RST_WR_POS;
            cfg_reg.mreq_pos <= RST_MREQ_POS;
            cfg_reg.iorq_pos <= RST_IORQ_POS;
            cfg_reg.wait_pos <= RST_WAIT_POS;
            cfg_reg.phi_pos  <= RST_PHI_POS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/cbce_decode.sv =====
// ----------------------------------------------------------------------------
// cbce_decode
// Pick control lines and the data byte out of one sample and classify it.
// ----------------------------------------------------------------------------
module cbce_decode
    import cbce_pkg::*;
(
    input  logic [SAMPLE_W-1:0] sample,
    input  cfg_t                cfg,
    output dec_t                dec
);

    logic                m1_n;
    logic                rd_n;
    logic                wr_n;
    logic                mreq_n;
    logic                iorq_n;
    logic [SAMPLE_W-1:0] shifted;

    assign m1_n    = sample[cfg.m1_pos];
    assign rd_n    = sample[cfg.rd_pos];
    assign wr_n    = sample[cfg.wr_pos];
    assign mreq_n  = sample[cfg.mreq_pos];
    assign iorq_n  = sample[cfg.iorq_pos];
    // zeros shift in above bit 15
    assign shifted = sample >> cfg.data_pos;

    always_comb
    begin
        dec.data     = shifted[DATA_W-1:0];
        dec.wait_n   = sample[cfg.wait_pos];
        dec.no_clock = cfg.phi_pos[PHI_W-1];
        dec.phi      = cfg.phi_pos[PHI_W-1] ? 1'b0 : sample[cfg.phi_pos[POS_W-1:0]];

        priority if (!mreq_n)
        begin
            priority if (!rd_n)
                dec.kind = m1_n ? KIND_MEM_RD : KIND_FETCH;
            else if (!wr_n)
                dec.kind = KIND_MEM_WR;
            else
                dec.kind = KIND_NONE;
        end
        else if (!iorq_n)
        begin
            priority if (!m1_n)
                dec.kind = KIND_INT_ACK;
            else if (!rd_n)
                dec.kind = KIND_IO_RD;
            else if (!wr_n)
                dec.kind = KIND_IO_WR;
            else
                dec.kind = KIND_NONE;
        end
        else
        begin
            dec.kind = KIND_NONE;
        end
    end

endmodule

// ===== src/cbce_span.sv =====
// ----------------------------------------------------------------------------
// cbce_span
// Span state: previous sample, held cycle, saturating counters and the
// sample index. Advance once per decoded sample and flag a summary on a
// cycle start.
// ----------------------------------------------------------------------------
module cbce_span
    import cbce_pkg::*;
#(
    parameter int INDEX_RING = DEF_INDEX_RING,
    parameter int COUNT_BITS = DEF_COUNT_BITS
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  dec_t    dec,
    output logic    emit,
    output result_t result
);

    localparam int IDX_BITS = (INDEX_RING > 1) ? $clog2(INDEX_RING) : 1;
    localparam logic [IDX_BITS-1:0] IDX_LAST = IDX_BITS'(INDEX_RING - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;

    kind_t                 last_kind_reg, last_kind_next;
    logic [DATA_W-1:0]     last_data_reg, last_data_next;
    logic                  last_clock_reg, last_clock_next;
    logic                  last_wait_reg, last_wait_next;
    kind_t                 held_kind_reg, held_kind_next;
    logic [DATA_W-1:0]     held_data_reg, held_data_next;
    logic [COUNT_BITS-1:0] samples_reg, samples_next;
    logic [COUNT_BITS-1:0] clocks_reg, clocks_next;
    logic [COUNT_BITS-1:0] waits_reg, waits_next;
    logic [IDX_BITS-1:0]   start_reg, start_next;
    logic [IDX_BITS-1:0]   pos_reg, pos_next;

    logic                  changed;
    logic                  cyc_start;
    logic                  cyc_end;
    logic                  clock_edge;
    logic [COUNT_BITS-1:0] samples_inc;
    logic [COUNT_BITS-1:0] clocks_inc;
    logic [COUNT_BITS-1:0] waits_inc;
    logic [31:0]           samples_ext;
    logic [31:0]           clocks_ext;
    logic [31:0]           waits_ext;
    logic [31:0]           start_ext;

    assign changed    = (dec.kind != last_kind_reg);
    assign cyc_start  = changed && (dec.kind != KIND_NONE);
    assign cyc_end    = changed && (dec.kind == KIND_NONE);
    assign clock_edge = dec.no_clock || (last_clock_reg && !dec.phi);

    // saturate at the counter top
    assign samples_inc = (samples_reg == COUNT_TOP) ? samples_reg : samples_reg + 1'b1;
    assign clocks_inc  = !clock_edge ? clocks_reg
                       : (clocks_reg == COUNT_TOP) ? clocks_reg : clocks_reg + 1'b1;
    assign waits_inc   = !(clock_edge && !last_wait_reg) ? waits_reg
                       : (waits_reg == COUNT_TOP) ? waits_reg : waits_reg + 1'b1;

    assign samples_ext = 32'(samples_inc);
    assign clocks_ext  = 32'(clocks_inc);
    assign waits_ext   = 32'(waits_inc);
    assign start_ext   = 32'(start_reg);

    always_comb
    begin
        held_kind_next  = cyc_end ? last_kind_reg : held_kind_reg;
        held_data_next  = cyc_end ? last_data_reg : held_data_reg;
        samples_next    = cyc_start ? '0 : samples_inc;
        clocks_next     = cyc_start ? '0 : clocks_inc;
        waits_next      = cyc_start ? '0 : waits_inc;
        start_next      = cyc_start ? pos_reg : start_reg;
        last_kind_next  = dec.kind;
        last_data_next  = dec.data;
        last_clock_next = dec.phi;
        last_wait_next  = dec.wait_n;
        pos_next        = (pos_reg == IDX_LAST) ? '0 : pos_reg + 1'b1;
    end

    assign emit = cyc_start;

    always_comb
    begin
        result.cycle_kind        = held_kind_next;
        result.cycle_data        = held_data_next;
        result.sample_count      = samples_ext[COUNT_OUT_W-1:0];
        result.clock_count       = clocks_ext[COUNT_OUT_W-1:0];
        result.wait_count        = waits_ext[COUNT_OUT_W-1:0];
        result.start_index       = start_ext[INDEX_OUT_W-1:0];
        result.direct_transition = cyc_start && (last_kind_reg != KIND_NONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_kind_reg  <= KIND_NONE;
            last_data_reg  <= '0;
            last_clock_reg <= 1'b0;
            last_wait_reg  <= 1'b0;
            held_kind_reg  <= KIND_NONE;
            held_data_reg  <= '0;
            samples_reg    <= '0;
            clocks_reg     <= '0;
            waits_reg      <= '0;
            start_reg      <= '0;
            pos_reg        <= '0;
        end
        else if (step)
        begin
            last_kind_reg  <= last_kind_next;
            last_data_reg  <= last_data_next;
            last_clock_reg <= last_clock_next;
            last_wait_reg  <= last_wait_next;
            held_kind_reg  <= held_kind_next;
            held_data_reg  <= held_data_next;
            samples_reg    <= samples_next;
            clocks_reg     <= clocks_next;
            waits_reg      <= waits_next;
            start_reg      <= start_next;
            pos_reg        <= pos_next;
        end
    end

endmodule
